// ----- hdl/tpm_pkg.sv -----
// Shared types and constants for the true-peak and RMS meter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

  localparam int SMP_W   = 24;
  localparam int SUM_W   = 59;
  localparam int CNT_W   = 13;
  localparam int ACC_W   = 43;
  localparam int SQ_W    = 47;
  localparam int RMS_W   = 23;
  localparam int MAC_STEPS = 24;
  localparam int PK_STEPS  = 4;

  // Q1.17 tap magnitudes, rows are interpolated points, columns oldest first
  localparam logic [3:0][3:0][23:0] COEF_MAG = '{
    '{24'd13624, 24'd30654, 24'd122616, 24'd20436},
    '{24'd28342, 24'd99199, 24'd66133,  24'd24800},
    '{24'd24800, 24'd66133, 24'd99199,  24'd28342},
    '{24'd20436, 24'd122616, 24'd30654, 24'd13624}
  };
  // outer taps are negative
  localparam logic [3:0] COEF_NEG = 4'b1001;

  typedef struct packed {
    logic [SMP_W-1:0] peak;
    logic [SQ_W-1:0]  sq;
  } mac_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/true_peak_and_rms_meter_unit.sv -----
// Top level of the true-peak and RMS meter: per-channel state and sequencing.
// Depends on tpm_pkg, tpm_mac and tpm_divsqrt.
//
// One request carries a sample for one channel. The block handles one request
// at a time: a sample that does not end a block passes through the bit-serial
// filter and square unit (24 steps) and its 4-step peak search. A sample that
// ends a block then also goes through the serial divider (59 steps) and square
// root (30 steps), and waits while the previous result has not been taken.
// Requests for a channel at or above CHANNELS are dropped.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module true_peak_and_rms_meter_unit #(
  parameter int CHANNELS  = 8,
  parameter int BLOCK_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // chan[2:0], sample[26:3]
  input  logic        in_tlast,   // block_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // out_chan[2:0], true_peak[26:3], rms_level[49:27]
);
  import tpm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t              state_r, state_nxt;
  logic [2:0]          chan_r;
  logic                end_r;
  logic [SMP_W-1:0]    smp_r;
  logic [SMP_W-1:0]    hist_r [CHANNELS][3];
  logic [SMP_W-1:0]    peak_r [CHANNELS];
  logic [SUM_W-1:0]    sum_r  [CHANNELS];
  logic [CNT_W-1:0]    cnt_r  [CHANNELS];
  logic [SMP_W-1:0]    res_pk_r;
  logic                out_valid_r;
  logic [55:0]         out_data_r;

  logic                accept, in_range, mac_start, mac_done, ds_start, ds_done, out_load;
  logic [CH_W-1:0]     idx_in, idx_r;
  logic [3:0][23:0]    win;
  mac_res_t            mac_res;
  logic [SMP_W-1:0]    pk;
  logic [SUM_W-1:0]    sum_nxt;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                blk_end;
  logic [RMS_W-1:0]    rms;

  assign idx_in   = in_tdata[CH_W-1:0];
  assign idx_r    = chan_r[CH_W-1:0];
  assign in_range = {1'b0, in_tdata[2:0]} < 4'(CHANNELS);
  assign accept   = in_tvalid && in_tready;

  assign win[0] = hist_r[idx_in][0];
  assign win[1] = hist_r[idx_in][1];
  assign win[2] = hist_r[idx_in][2];
  assign win[3] = in_tdata[26:3];

  assign pk      = (mac_res.peak > peak_r[idx_r]) ? mac_res.peak : peak_r[idx_r];
  assign sum_nxt = sum_r[idx_r] + SUM_W'(mac_res.sq);
  assign cnt_nxt = cnt_r[idx_r] + 1'b1;
  assign blk_end = end_r || (cnt_nxt >= CNT_W'(BLOCK_MAX));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && in_range) state_nxt = ST_MAC;
      ST_MAC:  if (mac_done) state_nxt = blk_end ? ST_DIV : ST_IDLE;
      ST_DIV:  if (ds_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ds_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MAC:  ds_start = mac_done && blk_end;
      ST_OUT:  out_load = !out_valid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  assign mac_start = accept && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        hist_r[c][0] <= '0;
        hist_r[c][1] <= '0;
        hist_r[c][2] <= '0;
        peak_r[c]    <= '0;
        sum_r[c]     <= '0;
        cnt_r[c]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_MAC && mac_done) begin
        hist_r[idx_r][0] <= hist_r[idx_r][1];
        hist_r[idx_r][1] <= hist_r[idx_r][2];
        hist_r[idx_r][2] <= smp_r;
        peak_r[idx_r]    <= blk_end ? '0 : pk;
        sum_r[idx_r]     <= blk_end ? '0 : sum_nxt;
        cnt_r[idx_r]     <= blk_end ? '0 : cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r <= in_tdata[2:0];
      smp_r  <= in_tdata[26:3];
      end_r  <= in_tlast;
    end
    if (ds_start) begin
      res_pk_r <= pk;
    end
    if (out_load) begin
      out_data_r <= {6'd0, rms, res_pk_r, chan_r};
    end
  end

  tpm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .win   (win),
    .done  (mac_done),
    .res   (mac_res)
  );

  tpm_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ds_start),
    .num   (sum_nxt),
    .den   (cnt_nxt),
    .done  (ds_done),
    .root  (rms)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- hdl/tpm_mac.sv -----
// Bit-serial interpolation filters, sample square and peak search.
// Depends on tpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpm_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [3:0][23:0]      win,
  output logic                  done,
  output tpm_pkg::mac_res_t     res
);
  import tpm_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [4:0]               step_r;
  logic [3:0][SMP_W-1:0]    win_r;
  logic [ACC_W-1:0]         acc_r [4];
  logic [SQ_W-1:0]          sq_r;
  logic [SMP_W-1:0]         mag_r;
  logic [SMP_W-1:0]         cand_r;
  logic [4:0]               kb;
  logic                     mac_ph;
  logic [26:0]              part [4];
  logic [1:0]               pi;
  logic [ACC_W-1:0]         am;
  logic [ACC_W:0]           rnd;
  logic [SMP_W-1:0]         rsat;
  logic [SMP_W-1:0]         smag;

  assign kb     = 5'(MAC_STEPS - 1) - step_r;
  assign mac_ph = step_r < 5'(MAC_STEPS);
  assign pi     = step_r[1:0];
  assign smag   = win[3][SMP_W-1] ? (~win[3] + 1'b1) : win[3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      part[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (mac_ph && COEF_MAG[i][j][kb]) begin
          if (COEF_NEG[j]) begin
            part[i] = part[i] - {{3{win_r[j][SMP_W-1]}}, win_r[j]};
          end else begin
            part[i] = part[i] + {{3{win_r[j][SMP_W-1]}}, win_r[j]};
          end
        end
      end
    end
  end

  always_comb begin
    am   = acc_r[pi][ACC_W-1] ? (~acc_r[pi] + 1'b1) : acc_r[pi];
    rnd  = {1'b0, am} + (ACC_W+1)'(65536);
    rsat = (|rnd[ACC_W:41]) ? '1 : rnd[40:17];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 5'(MAC_STEPS + PK_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      win_r  <= win;
      mag_r  <= smag;
      cand_r <= smag;
      sq_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else if (busy_r) begin
      if (mac_ph) begin
        for (int i = 0; i < 4; i++) begin
          acc_r[i] <= {acc_r[i][ACC_W-2:0], 1'b0} + {{16{part[i][26]}}, part[i]};
        end
        sq_r <= {sq_r[SQ_W-2:0], 1'b0} + (mag_r[kb] ? SQ_W'(mag_r) : '0);
      end else if (rsat > cand_r) begin
        cand_r <= rsat;
      end
    end
  end

  assign done     = done_r;
  assign res.peak = cand_r;
  assign res.sq   = sq_r;

endmodule
`default_nettype wire

// ----- hdl/tpm_divsqrt.sv -----
// Restoring bit-serial divide of the square sum by the count, then a
// digit-by-digit integer square root. Depends on tpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpm_divsqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpm_pkg::SUM_W-1:0]  num,
  input  logic [tpm_pkg::CNT_W-1:0]  den,
  output logic                       done,
  output logic [tpm_pkg::RMS_W-1:0]  root
);
  import tpm_pkg::*;

  localparam int SQ_STEPS = (SUM_W + 1) / 2;

  logic                 busy_r;
  logic                 done_r;
  logic                 sqph_r;
  logic [5:0]           step_r;
  logic [SUM_W:0]       sh_r;
  logic [31:0]          rem_r;
  logic [29:0]          root_r;
  logic [CNT_W-1:0]     den_r;
  logic [CNT_W:0]       drem;
  logic                 dge;
  logic [31:0]          srem;
  logic [31:0]          trial;
  logic                 sge;

  assign drem  = {rem_r[CNT_W-1:0], sh_r[SUM_W-1]};
  assign dge   = drem >= {1'b0, den_r};
  assign srem  = {rem_r[29:0], sh_r[SUM_W:SUM_W-1]};
  assign trial = {root_r, 2'b01};
  assign sge   = srem >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sqph_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sqph_r <= 1'b0;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (!sqph_r && step_r == 6'(SUM_W - 1)) begin
          sqph_r <= 1'b1;
          step_r <= '0;
        end else if (sqph_r && step_r == 6'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= {1'b0, num};
      den_r  <= den;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      if (!sqph_r) begin
        sh_r <= {1'b0, sh_r[SUM_W-2:0], dge};
        if (step_r == 6'(SUM_W - 1)) begin
          rem_r <= '0;
        end else begin
          rem_r <= {{(32-CNT_W){1'b0}},
                    dge ? CNT_W'(drem - {1'b0, den_r}) : drem[CNT_W-1:0]};
        end
      end else begin
        sh_r   <= {sh_r[SUM_W-2:0], 2'b00};
        rem_r  <= sge ? (srem - trial) : srem;
        root_r <= {root_r[28:0], sge};
      end
    end
  end

  assign done = done_r;
  assign root = (|root_r[29:RMS_W]) ? '1 : root_r[RMS_W-1:0];

endmodule
`default_nettype wire
